// File: design/ulsh_pkg.sv
// Package for the UART link sleep handshake: word types, event codes and register map.
`default_nettype none

package ulsh_pkg;

   // Event codes carried in the request word
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_DATA    = 3'd1,
      OP_PARTNER = 3'd2,
      OP_START   = 3'd3,
      OP_STOP    = 3'd4,
      OP_OPEN    = 3'd5
   } op_type;

   // Register port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned TIMEOUT_W  = 16;
   // Register index is the word address bit, paddr[2]
   localparam logic        IDX_IDLE_TIMEOUT   = 1'b0;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

   typedef struct packed {
      op_type opcode;
      logic   partner_wake_level;
      logic   tx_fifo_empty;
      logic   uart_attached;
   } req_word_type;

   typedef struct packed {
      logic wake_out_level;
      logic uart_power_on;
      logic asleep_flag;
      logic protocol_active;
      logic timer_active;
   } rsp_word_type;

   // Link state kept between events
   typedef struct packed {
      logic                 proto_on;
      logic                 tx_seen;
      logic                 sleeping;
      logic                 wake_drive;
      logic                 uart_power;
      logic                 timer_running;
      logic [TIMEOUT_W-1:0] timer_count;
   } link_state_type;

endpackage

`default_nettype wire

// File: design/uart_link_sleep_handshake_unit.sv
// Top level of the UART link sleep handshake: input register, event logic, result register.
//
//  Channel   Direction  Handshake                     Word
//  req_      in         req_valid / req_stall         ulsh_pkg::req_word_type
//  rsp_      out        rsp_valid / rsp_stall         ulsh_pkg::rsp_word_type
//  csr       in/out     psel penable pwrite pready    idle_timeout_ticks at byte 0
//
// One event per clock sustained while rsp_stall is low. Each event passes the input
// register, then the state update and result register in the same cycle.
// Reset is synchronous and active high; the timeout register returns to 3000 ticks.
// A stalled result holds; the input register keeps taking one more word while the
// result waits, then req_stall rises until the result is taken.
`default_nettype none

module uart_link_sleep_handshake_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // event channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ulsh_pkg::req_word_type              req_data,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ulsh_pkg::rsp_word_type                   rsp_data,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [ulsh_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [ulsh_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ulsh_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);

   logic [ulsh_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic                           s1_vld_ff;
   ulsh_pkg::req_word_type         s1_data_ff;
   logic                           rsp_vld_ff;
   ulsh_pkg::rsp_word_type         rsp_data_ff;
   ulsh_pkg::link_state_type       state_ff;
   ulsh_pkg::link_state_type       state_in;
   logic                           out_free;
   logic                           s1_go;
   logic                           s1_free;
   logic                           csr_wr;

   // Timer reload
   function automatic ulsh_pkg::link_state_type f_restart(
      input ulsh_pkg::link_state_type st,
      input logic [ulsh_pkg::TIMEOUT_W-1:0] tmo);
      ulsh_pkg::link_state_type r;
      r = st;
      r.timer_running = 1'b1;
      r.timer_count   = tmo;
      return r;
   endfunction

   // Wake the link, power change only with a port attached
   function automatic ulsh_pkg::link_state_type f_wakeup(
      input ulsh_pkg::link_state_type st,
      input logic partner, input logic attached,
      input logic [ulsh_pkg::TIMEOUT_W-1:0] tmo);
      ulsh_pkg::link_state_type r;
      r = st;
      if (st.sleeping) begin
         r = f_restart(r, tmo);
         r.wake_drive = 1'b0;
         r.sleeping   = 1'b0;
         if (attached) begin
            r.uart_power = 1'b1;
         end
      end else if (partner) begin
         r.wake_drive = 1'b0;
         r = f_restart(r, tmo);
      end
      return r;
   endfunction

   // Decide between sleep, timer reload and wakeup
   function automatic ulsh_pkg::link_state_type f_sleep_eval(
      input ulsh_pkg::link_state_type st,
      input logic partner, input logic fifo_empty, input logic attached,
      input logic [ulsh_pkg::TIMEOUT_W-1:0] tmo);
      ulsh_pkg::link_state_type r;
      r = st;
      if (st.wake_drive && partner && attached) begin
         if (!st.sleeping) begin
            if (fifo_empty) begin
               r.sleeping   = 1'b1;
               r.uart_power = 1'b0;
            end else begin
               r = f_restart(r, tmo);
            end
         end
      end else begin
         r = f_wakeup(st, partner, attached, tmo);
      end
      return r;
   endfunction

   // Handshake control
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign s1_go     = s1_vld_ff && out_free;
   assign s1_free   = !s1_vld_ff || s1_go;
   assign req_stall = !s1_free;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[2] == ulsh_pkg::IDX_IDLE_TIMEOUT);
   always_comb begin
      prdata = '0;
      if (paddr[2] == ulsh_pkg::IDX_IDLE_TIMEOUT) begin
         prdata = {{(ulsh_pkg::CSR_DATA_W-ulsh_pkg::TIMEOUT_W){1'b0}}, timeout_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ulsh_pkg::TIMEOUT_RESET;
      end else if (csr_wr) begin
         timeout_ff <= pwdata[ulsh_pkg::TIMEOUT_W-1:0];
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_free) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_valid) begin
         s1_data_ff <= req_data;
      end
   end

   // Event logic
   always_comb begin
      state_in = state_ff;
      case (s1_data_ff.opcode)
         ulsh_pkg::OP_TICK: begin
            if (state_ff.timer_running) begin
               if (state_ff.timer_count <= ulsh_pkg::TIMEOUT_W'(1)) begin
                  state_in.timer_running = 1'b0;
                  state_in.timer_count   = '0;
                  if (!state_ff.tx_seen) begin
                     state_in.wake_drive = 1'b1;
                     state_in = f_sleep_eval(state_in, s1_data_ff.partner_wake_level,
                                             s1_data_ff.tx_fifo_empty,
                                             s1_data_ff.uart_attached, timeout_ff);
                  end else begin
                     state_in = f_restart(state_in, timeout_ff);
                  end
                  state_in.tx_seen = 1'b0;
               end else begin
                  state_in.timer_count = state_ff.timer_count - ulsh_pkg::TIMEOUT_W'(1);
               end
            end
         end
         ulsh_pkg::OP_DATA: begin
            if (state_ff.proto_on) begin
               state_in.tx_seen = 1'b1;
               if (state_ff.wake_drive) begin
                  state_in = f_wakeup(state_in, s1_data_ff.partner_wake_level,
                                      s1_data_ff.uart_attached, timeout_ff);
               end
            end
         end
         ulsh_pkg::OP_PARTNER: begin
            if (state_ff.proto_on) begin
               state_in = f_sleep_eval(state_ff, s1_data_ff.partner_wake_level,
                                       s1_data_ff.tx_fifo_empty,
                                       s1_data_ff.uart_attached, timeout_ff);
            end
         end
         ulsh_pkg::OP_START: begin
            if (!state_ff.proto_on) begin
               state_in = f_restart(state_ff, timeout_ff);
               state_in.wake_drive = 1'b1;
               state_in.proto_on   = 1'b1;
            end
         end
         ulsh_pkg::OP_STOP: begin
            if (state_ff.proto_on) begin
               state_in.wake_drive    = 1'b0;
               state_in.timer_running = 1'b0;
               state_in.timer_count   = '0;
               state_in.proto_on      = 1'b0;
               if (state_ff.sleeping) begin
                  state_in.sleeping = 1'b0;
                  if (s1_data_ff.uart_attached) begin
                     state_in.uart_power = 1'b1;
                  end
               end
            end
         end
         ulsh_pkg::OP_OPEN: begin
            if (state_ff.proto_on && s1_data_ff.uart_attached) begin
               state_in.uart_power = 1'b1;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // Link state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.proto_on      <= 1'b0;
         state_ff.tx_seen       <= 1'b0;
         state_ff.sleeping      <= 1'b0;
         state_ff.wake_drive    <= 1'b1;
         state_ff.uart_power    <= 1'b1;
         state_ff.timer_running <= 1'b0;
         state_ff.timer_count   <= '0;
      end else if (s1_go) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff.wake_out_level  <= state_in.wake_drive;
         rsp_data_ff.uart_power_on   <= state_in.uart_power;
         rsp_data_ff.asleep_flag     <= state_in.sleeping;
         rsp_data_ff.protocol_active <= state_in.proto_on;
         rsp_data_ff.timer_active    <= state_in.timer_running;
      end
   end

   // Checks
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_go |=> s1_vld_ff)
      else $error("input word dropped while result stage blocked");

   a_sleep_needs_proto: assert property (@(posedge clock) disable iff (reset)
      state_ff.sleeping |-> state_ff.proto_on)
      else $error("asleep with protocol off");

   a_idle_timer_zero: assert property (@(posedge clock) disable iff (reset)
      !state_ff.timer_running |-> state_ff.timer_count == '0)
      else $error("stopped timer holds a count");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s1_go))
      else $error("result raised without an input word");

endmodule

`default_nettype wire
